// ===== hw/rtl/bbel_pkg.sv =====
// ----------------------------------------------------------------------------
// bbel_pkg
// Shared types, constants and arithmetic helpers for the Bethe-Bloch
// energy-loss pipeline (log2 squaring step, exp2 table, normalization).
// ----------------------------------------------------------------------------
package bbel_pkg;

  localparam int unsigned MOM_W     = 16;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LOG_STEPS = 30;
  localparam int unsigned EXP_STEPS = 30;
  localparam int unsigned QUO_W     = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORM       = 3'd0,
    CFG_OFFSET     = 3'd1,
    CFG_LOG_OFFSET = 3'd2,
    CFG_BETA_EXP   = 3'd3,
    CFG_INV_EXP    = 3'd4
  } cfg_reg_e;

  localparam logic [COEF_W-1:0] COEF_RESET = 32'h0001_0000;  // 1.0 in Q15.16
  localparam logic [32:0]       MASS_SQ_Q24 = 33'd326988;    // m^2 in Q24
  localparam logic [63:0]       MASS_Q24    = 64'd2342099;   // m in Q24
  localparam logic [29:0]       LN2_Q30     = 30'd744261118; // ln 2 in Q30

  // Position of the most significant set bit (0 for zero)
  function automatic logic [5:0] lead_one(input logic [63:0] x);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  // Align the leading one at bit 30
  function automatic logic [30:0] norm31(input logic [63:0] x, input logic [5:0] e);
    logic [63:0] t;
    if (e >= 6'd30) t = x >> (e - 6'd30);
    else            t = x << (6'd30 - e);
    return t[30:0];
  endfunction

  // One log2 fraction bit by squaring: returns {bit, next mantissa}
  function automatic logic [31:0] log_step(input logic [30:0] y);
    logic [61:0] p;
    logic [31:0] s;
    p = 62'(y) * 62'(y);
    s = p[61:30];
    if (s[31]) return {1'b1, s[31:1]};
    else       return {1'b0, s[30:0]};
  endfunction

  // Mantissa times table entry, Q30
  function automatic logic [30:0] exp_step(input logic [30:0] m, input logic [31:0] t);
    logic [62:0] p;
    p = 63'(m) * 63'(t);
    return p[60:30];
  endfunction

  // Integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bt;
    logic [63:0] v;
    v  = x;
    r  = '0;
    bt = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q30, by repeated square roots of 2.0
  function automatic logic [31:0] exp_tab(input int k);
    logic [63:0] t;
    t = 64'h8000_0000;
    for (int i = 1; i <= k; i++) begin
      t = isqrt64(t << 30);
    end
    return t[31:0];
  endfunction

  // log2 of a constant, Q30, same steps as the datapath
  function automatic logic [35:0] log2_const(input logic [63:0] x);
    logic [5:0]  e;
    logic [30:0] y;
    logic [31:0] s;
    logic [29:0] f;
    e = lead_one(x);
    y = norm31(x, e);
    f = '0;
    for (int k = 0; k < 30; k++) begin
      s = log_step(y);
      f = {f[28:0], s[31]};
      y = s[30:0];
    end
    return {e, f};
  endfunction

  localparam logic [35:0] LOG2_MASS = log2_const(MASS_Q24);

endpackage

// ===== hw/rtl/bbel_if.sv =====
// ----------------------------------------------------------------------------
// bbel_if
// Valid/ready channel interfaces: momentum in, result out, config write.
// ----------------------------------------------------------------------------
interface bbel_mom_if import bbel_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MOM_W-1:0] momentum;
  modport source (output valid, output momentum, input ready);
  modport sink   (input valid, input momentum, output ready);
endinterface

interface bbel_res_if import bbel_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] energy_loss;
  logic                     invalid;
  modport source (output valid, output energy_loss, output invalid, input ready);
  modport sink   (input valid, input energy_loss, input invalid, output ready);
endinterface

interface bbel_cfg_if import bbel_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bethe_bloch_energy_loss_top.sv =====
// Throughput: one item per cycle while the output skid register is empty; 140
// register stages (log2 squarings, exp2 steps, restoring divider).
// An output skid register takes one result while the consumer stalls.
// Reset (async, active low) clears valid bits, skid state and sets all five
// coefficients to 1.0.
// ----------------------------------------------------------------------------
// bethe_bloch_energy_loss_top
// Pipelined pion dE/dx from a five-coefficient Bethe-Bloch parameterization.
// ----------------------------------------------------------------------------
module bethe_bloch_energy_loss_top import bbel_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  bbel_cfg_if.sink cfg_i,
  bbel_mom_if.sink in_i,
  bbel_res_if.source res_o
);

  localparam int NST     = 140;
  localparam int ST_G    = 66;
  localparam int ST_LAST = NST - 1;

  localparam logic signed [39:0] Q30_TWELVE     = 40'sh03_0000_0000;
  localparam logic signed [39:0] Q30_THIRTYTWO  = 40'sh08_0000_0000;
  localparam logic signed [53:0] EXP_LIM        = 54'sh10_0000_0000;

  // Product of two partials, shifted by 16, signed and clamped to +-64.0
  function automatic logic [37:0] exp_arg(input logic [49:0] lo, input logic [49:0] hi,
                                          input logic neg);
    logic [67:0]        full;
    logic signed [53:0] y;
    full = {hi, 18'b0} + 68'(lo);
    y    = signed'({2'b00, full[67:16]});
    if (neg) y = -y;
    if (y > EXP_LIM)       y = EXP_LIM;
    else if (y < -EXP_LIM) y = -EXP_LIM;
    return y[37:0];
  endfunction

  // Mantissa times 2^(n+2), saturated at 2^62
  function automatic logic [62:0] exp_scale(input logic [30:0] m, input logic signed [7:0] n);
    logic signed [8:0] s;
    logic [63:0]       v;
    s = 9'(n) + 9'sd2;
    if (n >= 8'sd30)   v = 64'h4000_0000_0000_0000;
    else if (s >= 0)   v = 64'(m) << s[4:0];
    else               v = 64'(m) >> 6'(-s);
    return v[62:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  logic [COEF_W-1:0] c0_q, c1_q, c2_q, c3_q, c4_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= COEF_RESET;
      c1_q <= COEF_RESET;
      c2_q <= COEF_RESET;
      c3_q <= COEF_RESET;
      c4_q <= COEF_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_NORM:       c0_q <= cfg_i.data;
        CFG_OFFSET:     c1_q <= cfg_i.data;
        CFG_LOG_OFFSET: c2_q <= cfg_i.data;
        CFG_BETA_EXP:   c3_q <= cfg_i.data;
        CFG_INV_EXP:    c4_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: global advance, held while the skid register is full
  logic en;
  logic skid_full_q;
  logic vld_q [NST];
  logic inv_q [NST];
  logic arg_bad;

  assign en         = !skid_full_q;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) begin
        vld_q[s] <= 1'b0;
        inv_q[s] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      inv_q[0] <= (in_i.momentum == '0);
      for (int s = 1; s < NST; s++) begin
        vld_q[s] <= vld_q[s-1];
        inv_q[s] <= (s == ST_G) ? (inv_q[s-1] | arg_bad) : inv_q[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: p and p^2 + m^2
  logic [MOM_W-1:0] a_x1_q;
  logic [32:0]      a_x2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x1_q <= in_i.momentum;
      a_x2_q <= 33'(in_i.momentum) * 33'(in_i.momentum) + MASS_SQ_Q24;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1..31: two log2 units, normalize then one fraction bit per stage
  logic [30:0] lg_y1_q [LOG_STEPS+1];
  logic [29:0] lg_f1_q [LOG_STEPS+1];
  logic [5:0]  lg_e1_q [LOG_STEPS+1];
  logic [30:0] lg_y2_q [LOG_STEPS+1];
  logic [29:0] lg_f2_q [LOG_STEPS+1];
  logic [5:0]  lg_e2_q [LOG_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      lg_e1_q[0] <= lead_one(64'(a_x1_q));
      lg_y1_q[0] <= norm31(64'(a_x1_q), lead_one(64'(a_x1_q)));
      lg_f1_q[0] <= '0;
      lg_e2_q[0] <= lead_one(64'(a_x2_q));
      lg_y2_q[0] <= norm31(64'(a_x2_q), lead_one(64'(a_x2_q)));
      lg_f2_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_lg
    logic [31:0] s1, s2;
    assign s1 = log_step(lg_y1_q[k-1]);
    assign s2 = log_step(lg_y2_q[k-1]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        lg_y1_q[k] <= s1[30:0];
        lg_f1_q[k] <= {lg_f1_q[k-1][28:0], s1[31]};
        lg_e1_q[k] <= lg_e1_q[k-1];
        lg_y2_q[k] <= s2[30:0];
        lg_f2_q[k] <= {lg_f2_q[k-1][28:0], s2[31]};
        lg_e2_q[k] <= lg_e2_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 32: log2(beta) and log2(m/p)
  logic signed [39:0] lp_s, l2_s;
  logic signed [39:0] m_lb_q, m_lr_q;

  assign lp_s = signed'({4'b0000, lg_e1_q[LOG_STEPS], lg_f1_q[LOG_STEPS]});
  assign l2_s = signed'({4'b0000, lg_e2_q[LOG_STEPS], lg_f2_q[LOG_STEPS]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_lb_q <= lp_s - (l2_s >>> 1);
      m_lr_q <= signed'({4'b0000, LOG2_MASS}) - lp_s - Q30_TWELVE;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 33: exponent times log, two partial products each
  logic [35:0] ub_b, ub_r;
  logic [31:0] ua_b, ua_r;
  logic [49:0] p_bl_q, p_bh_q, p_rl_q, p_rh_q;
  logic        p_bs_q, p_rs_q;

  assign ub_b = m_lb_q[39] ? 36'(-m_lb_q) : 36'(m_lb_q);
  assign ub_r = m_lr_q[39] ? 36'(-m_lr_q) : 36'(m_lr_q);
  assign ua_b = c3_q[31] ? -c3_q : c3_q;
  assign ua_r = c4_q[31] ? -c4_q : c4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_bl_q <= 50'(ua_b) * 50'(ub_b[17:0]);
      p_bh_q <= 50'(ua_b) * 50'(ub_b[35:18]);
      p_bs_q <= c3_q[31] ^ m_lb_q[39];
      p_rl_q <= 50'(ua_r) * 50'(ub_r[17:0]);
      p_rh_q <= 50'(ua_r) * 50'(ub_r[35:18]);
      p_rs_q <= c4_q[31] ^ m_lr_q[39];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 34..64: two exp2 units, integer/fraction split then table steps
  logic [37:0]       y_b, y_r;
  logic [30:0]       ex_bm_q [EXP_STEPS+1];
  logic signed [7:0] ex_bn_q [EXP_STEPS+1];
  logic [29:0]       ex_bf_q [EXP_STEPS+1];
  logic [30:0]       ex_rm_q [EXP_STEPS+1];
  logic signed [7:0] ex_rn_q [EXP_STEPS+1];
  logic [29:0]       ex_rf_q [EXP_STEPS+1];

  assign y_b = exp_arg(p_bl_q, p_bh_q, p_bs_q);
  assign y_r = exp_arg(p_rl_q, p_rh_q, p_rs_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_bm_q[0] <= 31'h4000_0000;
      ex_bn_q[0] <= signed'(y_b[37:30]);
      ex_bf_q[0] <= y_b[29:0];
      ex_rm_q[0] <= 31'h4000_0000;
      ex_rn_q[0] <= signed'(y_r[37:30]);
      ex_rf_q[0] <= y_r[29:0];
    end
  end

  for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_ex
    localparam logic [31:0] TabK = exp_tab(k);
    always_ff @(posedge clk_i) begin
      if (en) begin
        ex_bm_q[k] <= ex_bf_q[k-1][30-k] ? exp_step(ex_bm_q[k-1], TabK) : ex_bm_q[k-1];
        ex_bn_q[k] <= ex_bn_q[k-1];
        ex_bf_q[k] <= ex_bf_q[k-1];
        ex_rm_q[k] <= ex_rf_q[k-1][30-k] ? exp_step(ex_rm_q[k-1], TabK) : ex_rm_q[k-1];
        ex_rn_q[k] <= ex_rn_q[k-1];
        ex_rf_q[k] <= ex_rf_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 65: scale to Q32; a vanishing beta power becomes one LSB
  logic [62:0] b_scaled;
  logic [62:0] s_b_q, s_r_q;

  assign b_scaled = exp_scale(ex_bm_q[EXP_STEPS], ex_bn_q[EXP_STEPS]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_b_q <= (b_scaled == '0) ? 63'd1 : b_scaled;
      s_r_q <= exp_scale(ex_rm_q[EXP_STEPS], ex_rn_q[EXP_STEPS]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 66: log argument c2 + (m/p)^c4, flag nonpositive
  logic signed [63:0] arg_s;
  logic [62:0]        g_arg_q, g_b_q;

  assign arg_s   = signed'({{16{c2_q[31]}}, c2_q, 16'b0}) + signed'({1'b0, s_r_q});
  assign arg_bad = arg_s[63] || (arg_s == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_arg_q <= arg_s[62:0];
      g_b_q   <= s_b_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 67: leading-one search on the argument
  logic [62:0] h_x_q, h_b_q;
  logic [5:0]  h_e_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_e_q <= lead_one(64'(g_arg_q));
      h_x_q <= g_arg_q;
      h_b_q <= g_b_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 68..98: log2 of the argument
  logic [30:0] la_y_q [LOG_STEPS+1];
  logic [29:0] la_f_q [LOG_STEPS+1];
  logic [5:0]  la_e_q [LOG_STEPS+1];
  logic [62:0] la_b_q [LOG_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      la_y_q[0] <= norm31(64'(h_x_q), h_e_q);
      la_f_q[0] <= '0;
      la_e_q[0] <= h_e_q;
      la_b_q[0] <= h_b_q;
    end
  end

  for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_la
    logic [31:0] s;
    assign s = log_step(la_y_q[k-1]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        la_y_q[k] <= s[30:0];
        la_f_q[k] <= {la_f_q[k-1][28:0], s[31]};
        la_e_q[k] <= la_e_q[k-1];
        la_b_q[k] <= la_b_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 99: log2(arg) - 32, split into sign and magnitude
  logic signed [39:0] z_s;
  logic [35:0]        z_mag_q;
  logic               z_neg_q;
  logic [62:0]        z_b_q;

  assign z_s = signed'({4'b0000, la_e_q[LOG_STEPS], la_f_q[LOG_STEPS]}) - Q30_THIRTYTWO;

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_mag_q <= z_s[39] ? 36'(-z_s) : 36'(z_s);
      z_neg_q <= z_s[39];
      z_b_q   <= la_b_q[LOG_STEPS];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 100: times ln 2, two partial products
  logic [47:0] q_lo_q, q_hi_q;
  logic        q_neg_q;
  logic [62:0] q_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_lo_q  <= 48'(LN2_Q30) * 48'(z_mag_q[17:0]);
      q_hi_q  <= 48'(LN2_Q30) * 48'(z_mag_q[35:18]);
      q_neg_q <= z_neg_q;
      q_b_q   <= z_b_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 101: natural log in Q30
  logic [65:0]        ln_full;
  logic signed [39:0] ln_pos;
  logic signed [39:0] l_ln_q;
  logic [62:0]        l_b_q;

  assign ln_full = {q_hi_q, 18'b0} + 66'(q_lo_q);
  assign ln_pos  = signed'({4'b0000, ln_full[65:30]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_ln_q <= q_neg_q ? -ln_pos : ln_pos;
      l_b_q  <= q_b_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 102: D = c1 - b - ln(arg) in Q32
  logic signed [63:0] d_s;
  logic [62:0]        d_mag_q, d_b_q;
  logic               d_neg_q;

  assign d_s = signed'({{16{c1_q[31]}}, c1_q, 16'b0}) - signed'({1'b0, l_b_q})
             - (64'(l_ln_q) <<< 2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_mag_q <= d_s[63] ? 63'(-d_s) : 63'(d_s);
      d_neg_q <= d_s[63];
      d_b_q   <= l_b_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 103..105: numerator |c0| * |D|, low half then high half
  logic [31:0] uc;
  logic [63:0] u_plo_q;
  logic [30:0] u_dh_q;
  logic        u_neg_q;
  logic [62:0] u_b_q;
  logic [62:0] w_phi_q;
  logic [63:0] w_plo_q;
  logic        w_neg_q;
  logic [62:0] w_b_q;
  logic [94:0] n_num_q;
  logic        n_neg_q;
  logic [62:0] n_b_q;

  assign uc = c0_q[31] ? -c0_q : c0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_plo_q <= 64'(uc) * 64'(d_mag_q[31:0]);
      u_dh_q  <= d_mag_q[62:32];
      u_neg_q <= d_neg_q;
      u_b_q   <= d_b_q;
      w_phi_q <= 63'(uc) * 63'(u_dh_q);
      w_plo_q <= u_plo_q;
      w_neg_q <= u_neg_q;
      w_b_q   <= u_b_q;
      n_num_q <= {w_phi_q, 32'b0} + 95'(w_plo_q);
      n_neg_q <= w_neg_q;
      n_b_q   <= w_b_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 106..138: overflow check, then restoring divide by b, one bit a stage
  logic [94:0]      dv_r_q   [QUO_W+1];
  logic [QUO_W-1:0] dv_q_q   [QUO_W+1];
  logic [62:0]      dv_b_q   [QUO_W+1];
  logic             dv_ovf_q [QUO_W+1];
  logic             dv_neg_q [QUO_W+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_r_q[0]   <= n_num_q;
      dv_q_q[0]   <= '0;
      dv_b_q[0]   <= n_b_q;
      dv_ovf_q[0] <= (n_num_q[94:32] >= n_b_q);
      dv_neg_q[0] <= n_neg_q;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_dv
    logic [94:0] bs;
    logic        ge;
    assign bs = 95'(dv_b_q[k-1]) << (QUO_W - k);
    assign ge = (dv_r_q[k-1] >= bs);
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_r_q[k]   <= ge ? (dv_r_q[k-1] - bs) : dv_r_q[k-1];
        dv_q_q[k]   <= dv_q_q[k-1] | (QUO_W'(ge) << (QUO_W - k));
        dv_b_q[k]   <= dv_b_q[k-1];
        dv_ovf_q[k] <= dv_ovf_q[k-1];
        dv_neg_q[k] <= dv_neg_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 139: sign and saturation
  logic [QUO_W-1:0]         f_quo;
  logic [QUO_W-1:0]         f_mag;
  logic                     f_ovf;
  logic                     f_neg;
  logic signed [COEF_W-1:0] f_e_d;
  logic signed [COEF_W-1:0] f_e_q;

  always_comb begin
    f_quo = dv_q_q[QUO_W];
    f_ovf = dv_ovf_q[QUO_W];
    f_neg = c0_q[31] ^ dv_neg_q[QUO_W];
    f_mag = f_quo;
    if (inv_q[ST_LAST-1]) begin
      f_e_d = '0;
    end else if (f_neg) begin
      if (f_ovf || (f_quo > 32'h8000_0000)) f_mag = 32'h8000_0000;
      f_e_d = signed'(-f_mag);
    end else begin
      if (f_ovf || (f_quo > 32'h7FFF_FFFF)) f_e_d = 32'sh7FFF_FFFF;
      else                                  f_e_d = signed'(f_quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_e_q <= f_e_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output skid register
  logic signed [COEF_W-1:0] skid_e_q;
  logic                     skid_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (res_o.ready) skid_full_q <= 1'b0;
    end else if (vld_q[ST_LAST] && !res_o.ready) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      skid_e_q   <= f_e_q;
      skid_inv_q <= inv_q[ST_LAST];
    end
  end

  assign res_o.valid       = skid_full_q | vld_q[ST_LAST];
  assign res_o.energy_loss = skid_full_q ? skid_e_q : f_e_q;
  assign res_o.invalid     = skid_full_q ? skid_inv_q : inv_q[ST_LAST];

endmodule

// ===== bench/bethe_bloch_energy_loss_top_tb.sv =====
// ----------------------------------------------------------------------------
// bethe_bloch_energy_loss_top_tb
// Self-checking bench for the pion dE/dx pipeline. A queue-fed driver sends
// momentum transactions and a monitor compares each result with a bit-exact
// fixed-point prediction. Coefficients change between phases, only while the
// pipe is drained. Sender and receiver stall at random in all but the last phases.
// ----------------------------------------------------------------------------
module bethe_bloch_energy_loss_top_tb;
  import bbel_pkg::*;

  localparam int          LATENCY_WAIT = 160;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam logic [63:0] Q30_MASK     = (64'd1 << 30) - 64'd1;

  typedef struct packed {
    logic signed [COEF_W-1:0] energy_loss;
    logic                     invalid;
  } dedx_t;

  logic clk_i;
  logic rst_ni;

  bbel_cfg_if cfg_bus ();
  bbel_mom_if mom_bus ();
  bbel_res_if res_bus ();

  bethe_bloch_energy_loss_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (mom_bus),
    .res_o  (res_bus)
  );

  logic [MOM_W-1:0]  pending_momentum[$];
  dedx_t             expected_dedx[$];
  logic [COEF_W-1:0] coef_shadow[5];
  int                send_idle_pct;
  int                recv_idle_pct;
  int                mismatches;
  int                tracks_sent;
  int                results_checked;
  int                invalid_seen;
  int                cycle_count;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bt;
    root = '0;
    bt   = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= root + bt) begin
        x    = x - (root + bt);
        root = (root >> 1) + bt;
      end else begin
        root = root >> 1;
      end
      bt = bt >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // (a*b) >> s, truncated toward zero
  function automatic longint scaled_product(input longint a, input longint b, input int s);
    logic [63:0] ua, ub, lo_mask, r;
    ua      = magnitude(a);
    ub      = magnitude(b);
    lo_mask = (64'd1 << s) - 64'd1;
    r       = ua * (ub >> s) + ((ua * (ub & lo_mask)) >> s);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // log2 in Q30, fraction by repeated squaring
  function automatic longint log2_q30(input logic [63:0] x);
    int          e;
    logic [63:0] y;
    logic [63:0] frac;
    if (x == 0) return 0;
    e = 63;
    while (!x[e]) e--;
    y    = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    frac = '0;
    for (int k = 0; k < 30; k++) begin
      y    = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        y    = y >> 1;
      end
    end
    return (longint'(e) <<< 30) | longint'(frac);
  endfunction

  // 2^y, y in Q30, result unsigned Q32 with saturation
  function automatic logic [63:0] exp2_q32(input longint y);
    longint      n;
    logic [63:0] f, u, mant, step;
    int          s;
    if (y > (64'sd64 <<< 30))  y = 64'sd64 <<< 30;
    if (y < -(64'sd64 <<< 30)) y = -(64'sd64 <<< 30);
    if (y >= 0) begin
      n = y >>> 30;
      f = 64'(y) & Q30_MASK;
    end else begin
      u = 64'(-y);
      n = -longint'(u >> 30);
      f = u & Q30_MASK;
      if (f != 0) begin
        n = n - 1;
        f = (64'd1 << 30) - f;
      end
    end
    if (n >= 30) return 64'd1 << 62;
    step = 64'd1 << 31;
    mant = 64'd1 << 30;
    for (int k = 1; k <= 30; k++) begin
      step = int_sqrt(step << 30);
      if (f[30-k]) mant = (mant * step) >> 30;
    end
    s = int'(n) + 2;
    if (s >= 0) return mant << s;
    if (-s >= 63) return 64'd0;
    return mant >> (-s);
  endfunction

  function automatic dedx_t pion_dedx(input logic [MOM_W-1:0] mom);
    dedx_t       out;
    longint      c0, c1, c2, c3, c4;
    longint      lp, lb, lr, arg, ln_arg, d;
    logic [63:0] b, r, ud, uc, q, rem, tq, tr, total;
    c0 = longint'($signed(coef_shadow[CFG_NORM]));
    c1 = longint'($signed(coef_shadow[CFG_OFFSET]));
    c2 = longint'($signed(coef_shadow[CFG_LOG_OFFSET]));
    c3 = longint'($signed(coef_shadow[CFG_BETA_EXP]));
    c4 = longint'($signed(coef_shadow[CFG_INV_EXP]));
    out.energy_loss = '0;
    out.invalid     = 1'b1;
    if (mom == 0) return out;
    // beta = p / sqrt(p^2 + m^2), ratio m/p, all as log2
    lp = log2_q30(64'(mom));
    lb = lp - log2_q30(64'(mom) * 64'(mom) + 64'(MASS_SQ_Q24)) / 2;
    lr = log2_q30(MASS_Q24) - lp - (64'sd12 <<< 30);
    b  = exp2_q32(scaled_product(c3, lb, 16));
    r  = exp2_q32(scaled_product(c4, lr, 16));
    if (b == 0) b = 64'd1;
    arg = c2 * 65536 + longint'(r);
    if (arg <= 0) return out;
    ln_arg = scaled_product(longint'(LN2_Q30), log2_q30(64'(arg)) - (64'sd32 <<< 30), 30);
    d  = c1 * 65536 - longint'(b) - ln_arg * 4;
    ud = magnitude(d);
    uc = magnitude(c0);
    q  = ud / b;
    rem = ud % b;
    tq = '0;
    tr = '0;
    // c0 * D / b with the remainder handled bit by bit
    if (uc != 0 && q > (64'd1 << 31)) begin
      total = 64'd1 << 32;
    end else begin
      for (int i = 31; i >= 0; i--) begin
        tq = tq << 1;
        tr = tr << 1;
        if (tr >= b) begin
          tr = tr - b;
          tq = tq + 1;
        end
        if (uc[i]) begin
          tr = tr + rem;
          if (tr >= b) begin
            tr = tr - b;
            tq = tq + 1;
          end
        end
      end
      total = uc * q + tq;
    end
    if ((c0 < 0) != (d < 0)) begin
      if (total > (64'd1 << 31)) total = 64'd1 << 31;
      out.energy_loss = 32'(-longint'(total));
    end else begin
      if (total > 64'h7FFF_FFFF) total = 64'h7FFF_FFFF;
      out.energy_loss = 32'(total);
    end
    out.invalid = 1'b0;
    return out;
  endfunction

  // ------------------------------------------------------------------ driver

  // Momentum source, fed from the pending queue
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mom_bus.valid <= 1'b0;
    end else if (!mom_bus.valid || mom_bus.ready) begin
      if (pending_momentum.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        mom_bus.valid    <= 1'b1;
        mom_bus.momentum <= pending_momentum.pop_front();
      end else begin
        mom_bus.valid <= 1'b0;
      end
    end
  end

  // Result sink backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) res_bus.ready <= 1'b1;
    else         res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    dedx_t want;
    if (rst_ni) begin
      // register writes update the shadow copy
      if (cfg_bus.valid && cfg_bus.ready && cfg_bus.index <= CFG_INV_EXP)
        coef_shadow[cfg_bus.index] = cfg_bus.data;
      // accepted input transaction: queue its prediction
      if (mom_bus.valid && mom_bus.ready) begin
        expected_dedx.push_back(pion_dedx(mom_bus.momentum));
        tracks_sent++;
      end
      // accepted result transaction: compare with the oldest prediction
      if (res_bus.valid && res_bus.ready) begin
        if (expected_dedx.size() == 0) begin
          $display("%0t: unexpected result energy_loss=%0d invalid=%0b", $time,
                   res_bus.energy_loss, res_bus.invalid);
          mismatches++;
        end else begin
          want = expected_dedx.pop_front();
          results_checked++;
          if (want.invalid) invalid_seen++;
          if (res_bus.energy_loss !== want.energy_loss) begin
            $display("%0t: energy_loss expected %0d actual %0d", $time,
                     want.energy_loss, res_bus.energy_loss);
            mismatches++;
          end
          if (res_bus.invalid !== want.invalid) begin
            $display("%0t: invalid expected %0b actual %0b", $time,
                     want.invalid, res_bus.invalid);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_dedx.size());
      $display("bethe_bloch_energy_loss_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  task automatic write_coef(input cfg_reg_e idx, input logic [COEF_W-1:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // Wait until every track has come back, then let the pipe empty.
  // Checked on the falling edge so driver and monitor updates have settled.
  task automatic drain_pipe();
    @(negedge clk_i);
    while (pending_momentum.size() != 0 || mom_bus.valid || expected_dedx.size() != 0)
      @(negedge clk_i);
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return COEF_RESET;
      4, 5, 6: return 32'($urandom_range(16 * 65536)) - 32'(8 * 65536);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [MOM_W-1:0] directed[$];
    rst_ni          = 1'b0;
    mom_bus.valid   = 1'b0;
    mom_bus.momentum = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = CFG_NORM;
    cfg_bus.data    = '0;
    res_bus.ready   = 1'b1;
    mismatches      = 0;
    tracks_sent     = 0;
    results_checked = 0;
    invalid_seen    = 0;
    cycle_count     = 0;
    send_idle_pct   = 28;
    recv_idle_pct   = 68;
    for (int i = 0; i < 5; i++) coef_shadow[i] = COEF_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: default coefficients, momentum extremes and zero momentum
    directed = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFF, 16'h8000, 16'h1000, 16'h0100,
                 16'h023C, 16'h0800, 16'h2000, 16'h7FFF, 16'hAAAA, 16'h5555};
    foreach (directed[i]) pending_momentum.push_back(directed[i]);
    drain_pipe();

    // Negative log offset: log argument goes nonpositive at high momentum
    write_coef(CFG_LOG_OFFSET, 32'hFFFE_0000);
    foreach (directed[i]) if (i < 5) pending_momentum.push_back(directed[i + 3]);
    drain_pipe();

    // Extreme exponents and scale: clamped powers, vanishing beta power
    write_coef(CFG_LOG_OFFSET, COEF_RESET);
    write_coef(CFG_BETA_EXP, 32'h7FFF_FFFF);
    write_coef(CFG_INV_EXP, 32'h8000_0000);
    write_coef(CFG_NORM, 32'h8000_0000);
    write_coef(CFG_OFFSET, 32'h7FFF_FFFF);
    pending_momentum.push_back(16'h0001);
    pending_momentum.push_back(16'hFFFF);
    pending_momentum.push_back(16'h1000);
    drain_pipe();
    write_coef(CFG_NORM, 32'h0000_0000);
    write_coef(CFG_BETA_EXP, 32'h8000_0000);
    write_coef(CFG_INV_EXP, 32'h7FFF_FFFF);
    pending_momentum.push_back(16'h0001);
    pending_momentum.push_back(16'hFFFF);
    pending_momentum.push_back(16'h0400);
    drain_pipe();

    // Random phases, each with a fresh coefficient set
    for (int phase = 0; phase < 7; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 28;
        recv_idle_pct = 68;
      end else if (phase < 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_coef(CFG_NORM, pick_coef());
      write_coef(CFG_OFFSET, pick_coef());
      write_coef(CFG_LOG_OFFSET, pick_coef());
      write_coef(CFG_BETA_EXP, pick_coef());
      write_coef(CFG_INV_EXP, pick_coef());
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(7) == 0) pending_momentum.push_back(MOM_W'($urandom_range(64)));
        else                        pending_momentum.push_back(MOM_W'($urandom));
      end
      drain_pipe();
    end

    $display("Checked %0d results from %0d tracks (%0d flagged invalid),", results_checked,
             tracks_sent, invalid_seen);
    $display("over default, extreme and random coefficient sets with varied stalls.");
    if (mismatches == 0) begin
      $display("bethe_bloch_energy_loss_top verification clean");
    end else begin
      $display("bethe_bloch_energy_loss_top verification failed");
    end
    $finish;
  end

endmodule
